/* sv/ubds_pkg.sv */
// Package for the serial baud divisor search.
// Holds the lane constants, status codes, candidate type and selection function.
// No dependencies.
package ubds_pkg;

    // search range and limits
    localparam logic [3:0]  OSR_TOP     = 4'hF;
    localparam int          NUM_LANES   = 8;
    localparam logic [15:0] BRG_MAX     = 16'hFFFF;
    localparam logic [31:0] Q_MAX       = 32'd65536;
    localparam int          DIV_BITS    = 32;
    localparam int          BAUD_W      = 24;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_ZERO  = 2'd2
    } t_status;

    // one candidate divisor setting
    typedef struct packed {
        logic        nofit;
        logic [31:0] err;
        logic [15:0] brg;
        logic [3:0]  osr;
    } t_cand;

    // a holds the higher osr; b replaces it when a does not fit, or when both fit and b has a strictly smaller error
    function automatic t_cand pick(input t_cand a, input t_cand b);
        t_cand r;
        if (b.nofit) begin
            r = a;
        end else if (a.nofit) begin
            r = b;
        end else if (b.err < a.err) begin
            r = b;
        end else begin
            r = a;
        end
        return r;
    endfunction

endpackage

/* sv/ubds_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a sideband payload alongside; depends on ubds_pkg.
module ubds_div
    import ubds_pkg::*;
#(
    parameter int W_SIDE = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [31:0]       i_dividend,
    input  logic [31:0]       i_divisor,
    input  logic [W_SIDE-1:0] i_side,
    output logic              o_valid,
    output logic [31:0]       o_quot,
    output logic [W_SIDE-1:0] o_side
);

    logic              c_vld  [0:DIV_BITS];
    logic [31:0]       c_rem  [0:DIV_BITS];
    logic [31:0]       c_dv   [0:DIV_BITS];
    logic [31:0]       c_dvsr [0:DIV_BITS];
    logic [W_SIDE-1:0] c_side [0:DIV_BITS];

    assign c_vld[0]  = i_valid;
    assign c_rem[0]  = '0;
    assign c_dv[0]   = i_dividend;
    assign c_dvsr[0] = i_divisor;
    assign c_side[0] = i_side;

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
        logic              r_vld;
        logic [31:0]       r_rem, r_dv, r_dvsr;
        logic [W_SIDE-1:0] r_side;
        logic [32:0]       n_trial;
        logic              n_ge;
        logic [31:0]       n_rem;

        // shift in the next dividend bit and try the subtract
        always_comb begin
            n_trial = {c_rem[k], c_dv[k][31]};
            n_ge    = n_trial >= {1'b0, c_dvsr[k]};
            n_rem   = n_ge ? 32'(n_trial - {1'b0, c_dvsr[k]}) : n_trial[31:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= c_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_dv   <= {c_dv[k][30:0], n_ge};
                r_dvsr <= c_dvsr[k];
                r_side <= c_side[k];
            end
        end

        assign c_vld[k+1]  = r_vld;
        assign c_rem[k+1]  = r_rem;
        assign c_dv[k+1]   = r_dv;
        assign c_dvsr[k+1] = r_dvsr;
        assign c_side[k+1] = r_side;
    end

    assign o_valid = c_vld[DIV_BITS];
    assign o_quot  = c_dv[DIV_BITS];
    assign o_side  = c_side[DIV_BITS];

endmodule

/* sv/ubds_sel.sv */
// Registered three-level minimum tree over the eight candidates, plus result formatting.
// Depends on ubds_pkg.
module ubds_sel
    import ubds_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic                        i_zero,
    input  t_cand [NUM_LANES-1:0]       i_cand,
    output logic                        o_valid,
    output logic [3:0]                  o_osr,
    output logic [15:0]                 o_brg,
    output logic [31:0]                 o_err,
    output t_status                     o_status
);

    logic        r_v1, r_v2, r_v3;
    logic        r_z1, r_z2;
    t_cand [3:0] r_c1;
    t_cand [1:0] r_c2;
    t_cand       n_win;
    logic [3:0]  r_osr;
    logic [15:0] r_brg;
    logic [31:0] r_err;
    t_status     r_status;

    assign n_win = pick(r_c2[0], r_c2[1]);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // tree levels; lower index always carries the higher osr
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_c1[k] <= pick(i_cand[2*k], i_cand[2*k+1]);
            end
            for (int k = 0; k < 2; k++) begin
                r_c2[k] <= pick(r_c1[2*k], r_c1[2*k+1]);
            end
            r_z1 <= i_zero;
            r_z2 <= r_z1;
            if (n_win.nofit) begin
                r_osr    <= OSR_TOP;
                r_brg    <= BRG_MAX;
                r_err    <= '0;
                r_status <= r_z2 ? ST_ZERO : ST_NOFIT;
            end else begin
                r_osr    <= n_win.osr;
                r_brg    <= n_win.brg;
                r_err    <= n_win.err;
                r_status <= ST_OK;
            end
        end
    end

    assign o_valid  = r_v3;
    assign o_osr    = r_osr;
    assign o_brg    = r_brg;
    assign o_err    = r_err;
    assign o_status = r_status;

endmodule

/* sv/uart_baud_divisor_search.sv */
// Top level of the serial baud divisor search: input stage, two divider arrays, selection.
// Depends on ubds_pkg, ubds_div and ubds_sel.
//
// A request (baud rate) enters on the slave stream and one result leaves on the master
// stream after passing through one input register, 32 stages of the quotient divider, one
// fit/candidate stage, 32 stages of the achieved-rate divider, one error stage and the
// three-level selection tree whose last level is the output register. Eight lanes, one per
// oversampling value 15..8, run side by side, so a new request is taken every cycle unless
// the pipeline holds. The whole pipeline holds while a result waits on the master side.
// The source clock register is written through i_cfg_we/i_cfg_wdata (reset 15 MHz) and
// must only change while no request is in flight.
module uart_baud_divisor_search
    import ubds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,   // clock_hz
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,     // [23:0] baud_bps
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,     // [3:0] osr_value, [19:4] brg_value,
                                       // [51:20] rate_error, [55:52] zero
    output logic [1:0]  o_m_tuser      // [1:0] status
);

    localparam int SIDE_B = 1 + 16 + BAUD_W;

    logic [31:0] r_clk_hz;
    logic        adv;

    // clock register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= 32'd15000000;
        end else if (i_cfg_we) begin
            r_clk_hz <= i_cfg_wdata;
        end
    end

    assign o_s_tready = adv;

    // input stage: divisor (osr+1)*baud per lane
    logic                r_s0_vld;
    logic [BAUD_W-1:0]   r_s0_baud;
    logic [31:0]         r_s0_dvsr [NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (adv) begin
            r_s0_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_baud <= i_s_tdata;
            for (int k = 0; k < NUM_LANES; k++) begin
                r_s0_dvsr[k] <= 32'(32'(i_s_tdata) * 32'(16 - k));
            end
        end
    end

    // quotient dividers
    logic              a_vld  [NUM_LANES];
    logic [31:0]       a_quot [NUM_LANES];
    logic [BAUD_W-1:0] a_baud [NUM_LANES];

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_diva
        ubds_div #(.W_SIDE(BAUD_W)) u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (adv),
            .i_valid    (r_s0_vld),
            .i_dividend (r_clk_hz),
            .i_divisor  (r_s0_dvsr[k]),
            .i_side     (r_s0_baud),
            .o_valid    (a_vld[k]),
            .o_quot     (a_quot[k]),
            .o_side     (a_baud[k])
        );
    end

    // fit check and second divisor (osr+1)*q
    logic              r_s1_vld;
    logic [SIDE_B-1:0] r_s1_side [NUM_LANES];
    logic [31:0]       r_s1_dvsr [NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= a_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                if (a_quot[k] != '0 && a_quot[k] <= Q_MAX) begin
                    r_s1_side[k] <= {1'b1, 16'(a_quot[k] - 32'd1), a_baud[k]};
                    r_s1_dvsr[k] <= 32'(32'(a_quot[k][16:0]) * 32'(16 - k));
                end else begin
                    r_s1_side[k] <= {1'b0, 16'd0, a_baud[k]};
                    r_s1_dvsr[k] <= 32'd1;
                end
            end
        end
    end

    // achieved-rate dividers
    logic              b_vld  [NUM_LANES];
    logic [31:0]       b_rate [NUM_LANES];
    logic [SIDE_B-1:0] b_side [NUM_LANES];

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_divb
        ubds_div #(.W_SIDE(SIDE_B)) u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (adv),
            .i_valid    (r_s1_vld),
            .i_dividend (r_clk_hz),
            .i_divisor  (r_s1_dvsr[k]),
            .i_side     (r_s1_side[k]),
            .o_valid    (b_vld[k]),
            .o_quot     (b_rate[k]),
            .o_side     (b_side[k])
        );
    end

    // error stage
    logic                  r_s2_vld;
    logic                  r_s2_zero;
    t_cand [NUM_LANES-1:0] r_s2_cand;
    logic [31:0]           n_baud [NUM_LANES];

    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            n_baud[k] = 32'(b_side[k][BAUD_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (adv) begin
            r_s2_vld <= b_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_zero <= b_side[0][BAUD_W-1:0] == '0;
            for (int k = 0; k < NUM_LANES; k++) begin
                r_s2_cand[k].nofit <= ~b_side[k][SIDE_B-1];
                r_s2_cand[k].brg   <= b_side[k][SIDE_B-2:BAUD_W];
                r_s2_cand[k].osr   <= 4'(15 - k);
                r_s2_cand[k].err   <= (b_rate[k] > n_baud[k]) ? b_rate[k] - n_baud[k]
                                                             : n_baud[k] - b_rate[k];
            end
        end
    end

    // selection and output register
    logic [3:0]  s_osr;
    logic [15:0] s_brg;
    logic [31:0] s_err;
    t_status     s_status;

    ubds_sel u_sel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_valid  (r_s2_vld),
        .i_zero   (r_s2_zero),
        .i_cand   (r_s2_cand),
        .o_valid  (o_m_tvalid),
        .o_osr    (s_osr),
        .o_brg    (s_brg),
        .o_err    (s_err),
        .o_status (s_status)
    );

    assign adv       = ~o_m_tvalid | i_m_tready;
    assign o_m_tdata = {4'd0, s_err, s_brg, s_osr};
    assign o_m_tuser = s_status;

endmodule
